/* rtl/core/rank2_tensor_frame_rotation_top_assert.svh */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef RANK2_TENSOR_FRAME_ROTATION_TOP_ASSERT_SVH
`define RANK2_TENSOR_FRAME_ROTATION_TOP_ASSERT_SVH

// clocked check, off while reset is asserted
`define R2TFR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// clocked check that also holds during reset
`define R2TFR_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/r2tfr_pkg.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation package
// Default widths, pipeline depth and the sqrt(3/2) constant generator.
// ----------------------------------------------------------------------------
package r2tfr_pkg;

	localparam int COMP_WIDTH_DEF = 24;
	localparam int TRIG_FRAC_DEF  = 14;

	// register stages from input to output
	localparam int PIPE_DEPTH = 4;

	// nearest integer to sqrt(3 * 2^(2*frac-1)), i.e. sqrt(3/2) in Q.frac
	// evaluated at elaboration only
	function automatic longint unsigned root_three_halves(input int frac);
		longint unsigned n;
		longint unsigned s;
		longint unsigned t;
		longint unsigned b;
		n = 64'd3 << (2 * frac - 1);
		s = 64'd0;
		b = 64'd1 << 31;
		for (int i = 0; i < 32; i++) begin
			t = s + b;
			if (t * t <= n) begin
				s = t;
			end
			b = b >> 1;
		end
		if (n - s * s > s) begin
			s = s + 64'd1;
		end
		return s;
	endfunction

endpackage

/* rtl/core/r2tfr_if.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation channels
// Valid/ready item channels for tensor input and rotated output.
// ----------------------------------------------------------------------------
interface r2tfr_in_if #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COMP_WIDTH-1:0]  comp0_re;
	logic signed [COMP_WIDTH-1:0]  comp1_re;
	logic signed [COMP_WIDTH-1:0]  comp1_im;
	logic signed [COMP_WIDTH-1:0]  comp2_re;
	logic signed [COMP_WIDTH-1:0]  comp2_im;
	logic signed [TRIG_FRAC+1:0]   cos_two_alpha;
	logic signed [TRIG_FRAC+1:0]   sin_two_alpha;
	logic signed [TRIG_FRAC+1:0]   cos_alpha;
	logic signed [TRIG_FRAC+1:0]   sin_alpha;
	logic signed [TRIG_FRAC+1:0]   cos_beta;
	logic signed [TRIG_FRAC+1:0]   sin_beta;

	modport source (
		output valid, comp0_re, comp1_re, comp1_im, comp2_re, comp2_im,
		output cos_two_alpha, sin_two_alpha, cos_alpha, sin_alpha,
		output cos_beta, sin_beta,
		input  ready
	);
	modport sink (
		input  valid, comp0_re, comp1_re, comp1_im, comp2_re, comp2_im,
		input  cos_two_alpha, sin_two_alpha, cos_alpha, sin_alpha,
		input  cos_beta, sin_beta,
		output ready
	);
endinterface

interface r2tfr_out_if #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COMP_WIDTH-1:0]  rot0_re;
	logic signed [COMP_WIDTH-1:0]  rot1_re;
	logic signed [COMP_WIDTH-1:0]  rot1_im;
	logic signed [COMP_WIDTH-1:0]  rot2_re;
	logic signed [COMP_WIDTH-1:0]  rot2_im;
	logic                          saturated_flag;

	modport source (
		output valid, rot0_re, rot1_re, rot1_im, rot2_re, rot2_im, saturated_flag,
		input  ready
	);
	modport sink (
		input  valid, rot0_re, rot1_re, rot1_im, rot2_re, rot2_im, saturated_flag,
		output ready
	);
endinterface

/* rtl/core/rank2_tensor_frame_rotation_top.sv */
// Pipeline: four register stages in order: phase, coefficients, products, sum/saturate.
// Throughput: one item per cycle; each stage holds only while the one after it is full.
// Reset: arst_n clears all stage valid bits at once; no items are held after reset.
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation top level
// Alpha phase rotation and beta Wigner small-d mixing of a rank-2 tensor.
// ----------------------------------------------------------------------------
module rank2_tensor_frame_rotation_top #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	r2tfr_in_if.sink     item_in,
	r2tfr_out_if.source  item_out
);
	localparam int P_W  = COMP_WIDTH + 3;
	localparam int TW   = TRIG_FRAC + 2;
	localparam int CF_W = TRIG_FRAC + 6;
	localparam int PR_W = COMP_WIDTH + TRIG_FRAC + 9;
	localparam int IM_W = COMP_WIDTH + TRIG_FRAC + 5;

	logic                     v1, v2, v3, r2_rdy, r3_rdy, r4_rdy;
	logic signed [COMP_WIDTH-1:0] c0_s1, c0_s2;
	logic signed [P_W-1:0]    p1_s1, q1_s1, p2_s1, q2_s1;
	logic signed [P_W-1:0]    p1_s2, q1_s2, p2_s2, q2_s2;
	logic signed [TW+1:0]     cc_s1, cs_s1, ss_s1;
	logic signed [TW-1:0]     cb_s1, sb_s1, cb_s2, sb_s2;
	logic signed [CF_W-1:0]   w0p2_s2, w0p1_s2, w0p0_s2;
	logic signed [CF_W-1:0]   w1p2_s2, w1p1_s2, w1p0_s2;
	logic signed [CF_W-1:0]   w2p2_s2, w2p1_s2, w2p0_s2;
	logic signed [PR_W-1:0]   m0p2_s3, m0p1_s3, m0p0_s3;
	logic signed [PR_W-1:0]   m1p2_s3, m1p1_s3, m1p0_s3;
	logic signed [PR_W-1:0]   m2p2_s3, m2p1_s3, m2p0_s3;
	logic signed [IM_W-1:0]   cbq1_s3, sbq2_s3, cbq2_s3, sbq1_s3;

	r2tfr_phase #(.COMP_WIDTH(COMP_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_phase (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (item_in.valid),
		.in_ready      (item_in.ready),
		.comp0_re      (item_in.comp0_re),
		.comp1_re      (item_in.comp1_re),
		.comp1_im      (item_in.comp1_im),
		.comp2_re      (item_in.comp2_re),
		.comp2_im      (item_in.comp2_im),
		.cos_two_alpha (item_in.cos_two_alpha),
		.sin_two_alpha (item_in.sin_two_alpha),
		.cos_alpha     (item_in.cos_alpha),
		.sin_alpha     (item_in.sin_alpha),
		.cos_beta      (item_in.cos_beta),
		.sin_beta      (item_in.sin_beta),
		.out_valid     (v1),
		.out_ready     (r2_rdy),
		.c0_s1         (c0_s1),
		.p1_s1         (p1_s1),
		.q1_s1         (q1_s1),
		.p2_s1         (p2_s1),
		.q2_s1         (q2_s1),
		.cc_s1         (cc_s1),
		.cs_s1         (cs_s1),
		.ss_s1         (ss_s1),
		.cb_s1         (cb_s1),
		.sb_s1         (sb_s1)
	);

	r2tfr_coef #(.COMP_WIDTH(COMP_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2_rdy),
		.c0_s1     (c0_s1),
		.p1_s1     (p1_s1),
		.q1_s1     (q1_s1),
		.p2_s1     (p2_s1),
		.q2_s1     (q2_s1),
		.cc_s1     (cc_s1),
		.cs_s1     (cs_s1),
		.ss_s1     (ss_s1),
		.cb_s1     (cb_s1),
		.sb_s1     (sb_s1),
		.out_valid (v2),
		.out_ready (r3_rdy),
		.c0_s2     (c0_s2),
		.p1_s2     (p1_s2),
		.q1_s2     (q1_s2),
		.p2_s2     (p2_s2),
		.q2_s2     (q2_s2),
		.cb_s2     (cb_s2),
		.sb_s2     (sb_s2),
		.w0p2_s2   (w0p2_s2),
		.w0p1_s2   (w0p1_s2),
		.w0p0_s2   (w0p0_s2),
		.w1p2_s2   (w1p2_s2),
		.w1p1_s2   (w1p1_s2),
		.w1p0_s2   (w1p0_s2),
		.w2p2_s2   (w2p2_s2),
		.w2p1_s2   (w2p1_s2),
		.w2p0_s2   (w2p0_s2)
	);

	r2tfr_mult #(.COMP_WIDTH(COMP_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3_rdy),
		.c0_s2     (c0_s2),
		.p1_s2     (p1_s2),
		.q1_s2     (q1_s2),
		.p2_s2     (p2_s2),
		.q2_s2     (q2_s2),
		.cb_s2     (cb_s2),
		.sb_s2     (sb_s2),
		.w0p2_s2   (w0p2_s2),
		.w0p1_s2   (w0p1_s2),
		.w0p0_s2   (w0p0_s2),
		.w1p2_s2   (w1p2_s2),
		.w1p1_s2   (w1p1_s2),
		.w1p0_s2   (w1p0_s2),
		.w2p2_s2   (w2p2_s2),
		.w2p1_s2   (w2p1_s2),
		.w2p0_s2   (w2p0_s2),
		.out_valid (v3),
		.out_ready (r4_rdy),
		.m0p2_s3   (m0p2_s3),
		.m0p1_s3   (m0p1_s3),
		.m0p0_s3   (m0p0_s3),
		.m1p2_s3   (m1p2_s3),
		.m1p1_s3   (m1p1_s3),
		.m1p0_s3   (m1p0_s3),
		.m2p2_s3   (m2p2_s3),
		.m2p1_s3   (m2p1_s3),
		.m2p0_s3   (m2p0_s3),
		.cbq1_s3   (cbq1_s3),
		.sbq2_s3   (sbq2_s3),
		.cbq2_s3   (cbq2_s3),
		.sbq1_s3   (sbq1_s3)
	);

	r2tfr_sum #(.COMP_WIDTH(COMP_WIDTH), .TRIG_FRAC(TRIG_FRAC)) u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v3),
		.in_ready   (r4_rdy),
		.m0p2_s3    (m0p2_s3),
		.m0p1_s3    (m0p1_s3),
		.m0p0_s3    (m0p0_s3),
		.m1p2_s3    (m1p2_s3),
		.m1p1_s3    (m1p1_s3),
		.m1p0_s3    (m1p0_s3),
		.m2p2_s3    (m2p2_s3),
		.m2p1_s3    (m2p1_s3),
		.m2p0_s3    (m2p0_s3),
		.cbq1_s3    (cbq1_s3),
		.sbq2_s3    (sbq2_s3),
		.cbq2_s3    (cbq2_s3),
		.sbq1_s3    (sbq1_s3),
		.out_valid  (item_out.valid),
		.out_ready  (item_out.ready),
		.rot0_re_s4 (item_out.rot0_re),
		.rot1_re_s4 (item_out.rot1_re),
		.rot1_im_s4 (item_out.rot1_im),
		.rot2_re_s4 (item_out.rot2_re),
		.rot2_im_s4 (item_out.rot2_im),
		.sat_s4     (item_out.saturated_flag)
	);

endmodule

/* rtl/core/r2tfr_phase.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation: alpha phase stage
// Rotates the m=1 and m=2 parts by alpha and 2*alpha, forms beta squares and cos*sin.
// ----------------------------------------------------------------------------
module r2tfr_phase #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COMP_WIDTH-1:0]  comp0_re,
	input  logic signed [COMP_WIDTH-1:0]  comp1_re,
	input  logic signed [COMP_WIDTH-1:0]  comp1_im,
	input  logic signed [COMP_WIDTH-1:0]  comp2_re,
	input  logic signed [COMP_WIDTH-1:0]  comp2_im,
	input  logic signed [TRIG_FRAC+1:0]   cos_two_alpha,
	input  logic signed [TRIG_FRAC+1:0]   sin_two_alpha,
	input  logic signed [TRIG_FRAC+1:0]   cos_alpha,
	input  logic signed [TRIG_FRAC+1:0]   sin_alpha,
	input  logic signed [TRIG_FRAC+1:0]   cos_beta,
	input  logic signed [TRIG_FRAC+1:0]   sin_beta,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COMP_WIDTH-1:0]  c0_s1,
	output logic signed [COMP_WIDTH+2:0]  p1_s1,
	output logic signed [COMP_WIDTH+2:0]  q1_s1,
	output logic signed [COMP_WIDTH+2:0]  p2_s1,
	output logic signed [COMP_WIDTH+2:0]  q2_s1,
	output logic signed [TRIG_FRAC+3:0]   cc_s1,
	output logic signed [TRIG_FRAC+3:0]   cs_s1,
	output logic signed [TRIG_FRAC+3:0]   ss_s1,
	output logic signed [TRIG_FRAC+1:0]   cb_s1,
	output logic signed [TRIG_FRAC+1:0]   sb_s1
);
	localparam int TW    = TRIG_FRAC + 2;
	localparam int P_W   = COMP_WIDTH + 3;
	localparam int DOT_W = COMP_WIDTH + TW + 2;
	localparam int SQ_W  = 2 * TW + 1;
	localparam int T2_W  = TW + 2;

	localparam logic signed [DOT_W-1:0] HALF_DOT = DOT_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [SQ_W-1:0]  HALF_SQ  = SQ_W'(1) <<< (TRIG_FRAC - 1);

	logic                     valid_s1;
	logic signed [DOT_W-1:0]  p1_r, q1_r, p2_r, q2_r;
	logic signed [SQ_W-1:0]   cc_r, cs_r, ss_r;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	// rounded dot products, half up
	assign p1_r = (cos_alpha * comp1_re + sin_alpha * comp1_im + HALF_DOT) >>> TRIG_FRAC;
	assign q1_r = (cos_alpha * comp1_im - sin_alpha * comp1_re + HALF_DOT) >>> TRIG_FRAC;
	assign p2_r = (cos_two_alpha * comp2_re + sin_two_alpha * comp2_im + HALF_DOT)
		>>> TRIG_FRAC;
	assign q2_r = (cos_two_alpha * comp2_im - sin_two_alpha * comp2_re + HALF_DOT)
		>>> TRIG_FRAC;
	assign cc_r = (cos_beta * cos_beta + HALF_SQ) >>> TRIG_FRAC;
	assign cs_r = (cos_beta * sin_beta + HALF_SQ) >>> TRIG_FRAC;
	assign ss_r = (sin_beta * sin_beta + HALF_SQ) >>> TRIG_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			c0_s1 <= comp0_re;
			p1_s1 <= p1_r[P_W-1:0];
			q1_s1 <= q1_r[P_W-1:0];
			p2_s1 <= p2_r[P_W-1:0];
			q2_s1 <= q2_r[P_W-1:0];
			cc_s1 <= cc_r[T2_W-1:0];
			cs_s1 <= cs_r[T2_W-1:0];
			ss_s1 <= ss_r[T2_W-1:0];
			cb_s1 <= cos_beta;
			sb_s1 <= sin_beta;
		end
	end

endmodule

/* rtl/core/r2tfr_coef.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation: Wigner coefficient stage
// Scales beta terms by sqrt(3/2) and forms the nine small-d mixing weights.
// ----------------------------------------------------------------------------
module r2tfr_coef #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COMP_WIDTH-1:0]  c0_s1,
	input  logic signed [COMP_WIDTH+2:0]  p1_s1,
	input  logic signed [COMP_WIDTH+2:0]  q1_s1,
	input  logic signed [COMP_WIDTH+2:0]  p2_s1,
	input  logic signed [COMP_WIDTH+2:0]  q2_s1,
	input  logic signed [TRIG_FRAC+3:0]   cc_s1,
	input  logic signed [TRIG_FRAC+3:0]   cs_s1,
	input  logic signed [TRIG_FRAC+3:0]   ss_s1,
	input  logic signed [TRIG_FRAC+1:0]   cb_s1,
	input  logic signed [TRIG_FRAC+1:0]   sb_s1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COMP_WIDTH-1:0]  c0_s2,
	output logic signed [COMP_WIDTH+2:0]  p1_s2,
	output logic signed [COMP_WIDTH+2:0]  q1_s2,
	output logic signed [COMP_WIDTH+2:0]  p2_s2,
	output logic signed [COMP_WIDTH+2:0]  q2_s2,
	output logic signed [TRIG_FRAC+1:0]   cb_s2,
	output logic signed [TRIG_FRAC+1:0]   sb_s2,
	output logic signed [TRIG_FRAC+5:0]   w0p2_s2,
	output logic signed [TRIG_FRAC+5:0]   w0p1_s2,
	output logic signed [TRIG_FRAC+5:0]   w0p0_s2,
	output logic signed [TRIG_FRAC+5:0]   w1p2_s2,
	output logic signed [TRIG_FRAC+5:0]   w1p1_s2,
	output logic signed [TRIG_FRAC+5:0]   w1p0_s2,
	output logic signed [TRIG_FRAC+5:0]   w2p2_s2,
	output logic signed [TRIG_FRAC+5:0]   w2p1_s2,
	output logic signed [TRIG_FRAC+5:0]   w2p0_s2
);
	import r2tfr_pkg::*;

	localparam int TW   = TRIG_FRAC + 2;
	localparam int CF_W = TRIG_FRAC + 6;
	localparam int KP_W = 2 * TW + 3;

	localparam logic signed [TW-1:0]   K_C      = TW'(root_three_halves(TRIG_FRAC));
	localparam logic signed [KP_W-1:0] HALF_K   = KP_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [CF_W-1:0] ONE      = CF_W'(1) <<< TRIG_FRAC;

	logic                     valid_s2;
	logic signed [KP_W-1:0]   kss_r, kcs_r;
	logic signed [CF_W-1:0]   kss_e, kcs_e, cc_e, cs_e;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	assign kss_r = (K_C * ss_s1 + HALF_K) >>> TRIG_FRAC;
	assign kcs_r = (K_C * cs_s1 + HALF_K) >>> TRIG_FRAC;
	assign kss_e = kss_r[CF_W-1:0];
	assign kcs_e = kcs_r[CF_W-1:0];
	assign cc_e  = CF_W'(cc_s1);
	assign cs_e  = CF_W'(cs_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			c0_s2   <= c0_s1;
			p1_s2   <= p1_s1;
			q1_s2   <= q1_s1;
			p2_s2   <= p2_s1;
			q2_s2   <= q2_s1;
			cb_s2   <= cb_s1;
			sb_s2   <= sb_s1;
			// m=0 row, output scale is half (extra shift later)
			w0p2_s2 <= kss_e <<< 1;
			w0p1_s2 <= -(kcs_e <<< 2);
			w0p0_s2 <= (cc_e <<< 1) + cc_e - ONE;
			// m=1 row
			w1p2_s2 <= -cs_e;
			w1p1_s2 <= (cc_e <<< 1) - ONE;
			w1p0_s2 <= kcs_e;
			// m=2 row, half scale
			w2p2_s2 <= ONE + cc_e;
			w2p1_s2 <= cs_e <<< 1;
			w2p0_s2 <= kss_e;
		end
	end

endmodule

/* rtl/core/r2tfr_mult.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation: product stage
// Multiplies phased components by the mixing weights, one register level.
// ----------------------------------------------------------------------------
module r2tfr_mult #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [COMP_WIDTH-1:0]            c0_s2,
	input  logic signed [COMP_WIDTH+2:0]            p1_s2,
	input  logic signed [COMP_WIDTH+2:0]            q1_s2,
	input  logic signed [COMP_WIDTH+2:0]            p2_s2,
	input  logic signed [COMP_WIDTH+2:0]            q2_s2,
	input  logic signed [TRIG_FRAC+1:0]             cb_s2,
	input  logic signed [TRIG_FRAC+1:0]             sb_s2,
	input  logic signed [TRIG_FRAC+5:0]             w0p2_s2,
	input  logic signed [TRIG_FRAC+5:0]             w0p1_s2,
	input  logic signed [TRIG_FRAC+5:0]             w0p0_s2,
	input  logic signed [TRIG_FRAC+5:0]             w1p2_s2,
	input  logic signed [TRIG_FRAC+5:0]             w1p1_s2,
	input  logic signed [TRIG_FRAC+5:0]             w1p0_s2,
	input  logic signed [TRIG_FRAC+5:0]             w2p2_s2,
	input  logic signed [TRIG_FRAC+5:0]             w2p1_s2,
	input  logic signed [TRIG_FRAC+5:0]             w2p0_s2,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p2_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p1_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p0_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p2_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p1_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p0_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p2_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p1_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p0_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  cbq1_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  sbq2_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  cbq2_s3,
	output logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  sbq1_s3
);
	logic valid_s3;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			m0p2_s3 <= w0p2_s2 * p2_s2;
			m0p1_s3 <= w0p1_s2 * p1_s2;
			m0p0_s3 <= w0p0_s2 * c0_s2;
			m1p2_s3 <= w1p2_s2 * p2_s2;
			m1p1_s3 <= w1p1_s2 * p1_s2;
			m1p0_s3 <= w1p0_s2 * c0_s2;
			m2p2_s3 <= w2p2_s2 * p2_s2;
			m2p1_s3 <= w2p1_s2 * p1_s2;
			m2p0_s3 <= w2p0_s2 * c0_s2;
			cbq1_s3 <= cb_s2 * q1_s2;
			sbq2_s3 <= sb_s2 * q2_s2;
			cbq2_s3 <= cb_s2 * q2_s2;
			sbq1_s3 <= sb_s2 * q1_s2;
		end
	end

endmodule

/* rtl/core/r2tfr_sum.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation: sum and saturate stage
// Adds the products per output, rounds half up, clips, output register.
// ----------------------------------------------------------------------------
module r2tfr_sum #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF,
	parameter int TRIG_FRAC  = r2tfr_pkg::TRIG_FRAC_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p2_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p1_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m0p0_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p2_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p1_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m1p0_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p2_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p1_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+8:0]  m2p0_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  cbq1_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  sbq2_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  cbq2_s3,
	input  logic signed [COMP_WIDTH+TRIG_FRAC+4:0]  sbq1_s3,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [COMP_WIDTH-1:0]            rot0_re_s4,
	output logic signed [COMP_WIDTH-1:0]            rot1_re_s4,
	output logic signed [COMP_WIDTH-1:0]            rot1_im_s4,
	output logic signed [COMP_WIDTH-1:0]            rot2_re_s4,
	output logic signed [COMP_WIDTH-1:0]            rot2_im_s4,
	output logic                                    sat_s4
);
	localparam int ACC_W = COMP_WIDTH + TRIG_FRAC + 11;

	localparam logic signed [ACC_W-1:0] HALF_LO = ACC_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [ACC_W-1:0] HALF_HI = ACC_W'(1) <<< TRIG_FRAC;

	logic                     valid_s4;
	logic signed [ACC_W-1:0]  acc0, acc1, acc1i, acc2, acc2i;
	logic [COMP_WIDTH:0]      r0, r1, r1i, r2, r2i;

	// {clipped, value}; half_scale adds one more bit of right shift
	function automatic logic [COMP_WIDTH:0] round_sat(
		input logic signed [ACC_W-1:0] acc,
		input logic                    half_scale
	);
		logic signed [ACC_W-1:0]  rnd;
		logic                     ovf;
		logic [COMP_WIDTH-1:0]    val;
		if (half_scale) begin
			rnd = (acc + HALF_HI) >>> (TRIG_FRAC + 1);
		end else begin
			rnd = (acc + HALF_LO) >>> TRIG_FRAC;
		end
		// out of range when the bits above the sign are not a sign extension
		ovf = !(&rnd[ACC_W-1:COMP_WIDTH-1]) && (|rnd[ACC_W-1:COMP_WIDTH-1]);
		if (!ovf) begin
			val = rnd[COMP_WIDTH-1:0];
		end else if (rnd[ACC_W-1]) begin
			val = {1'b1, {(COMP_WIDTH-1){1'b0}}};
		end else begin
			val = {1'b0, {(COMP_WIDTH-1){1'b1}}};
		end
		return {ovf, val};
	endfunction

	assign in_ready  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;

	always_comb begin
		acc0  = m0p2_s3 + m0p1_s3 + m0p0_s3;
		acc1  = m1p2_s3 + m1p1_s3 + m1p0_s3;
		acc2  = m2p2_s3 + m2p1_s3 + m2p0_s3;
		acc1i = cbq1_s3 - sbq2_s3;
		acc2i = cbq2_s3 + sbq1_s3;
		r0    = round_sat(acc0, 1'b1);
		r1    = round_sat(acc1, 1'b0);
		r1i   = round_sat(acc1i, 1'b0);
		r2    = round_sat(acc2, 1'b1);
		r2i   = round_sat(acc2i, 1'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rot0_re_s4 <= r0[COMP_WIDTH-1:0];
			rot1_re_s4 <= r1[COMP_WIDTH-1:0];
			rot1_im_s4 <= r1i[COMP_WIDTH-1:0];
			rot2_re_s4 <= r2[COMP_WIDTH-1:0];
			rot2_im_s4 <= r2i[COMP_WIDTH-1:0];
			sat_s4     <= r0[COMP_WIDTH] | r1[COMP_WIDTH] | r1i[COMP_WIDTH]
				| r2[COMP_WIDTH] | r2i[COMP_WIDTH];
		end
	end

endmodule

/* rtl/core/r2tfr_checker.sv */
// ----------------------------------------------------------------------------
// Rank-2 tensor frame rotation checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
`include "rank2_tensor_frame_rotation_top_assert.svh"

module r2tfr_checker #(
	parameter int COMP_WIDTH = r2tfr_pkg::COMP_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [COMP_WIDTH-1:0]  rot0_re,
	input  logic [COMP_WIDTH-1:0]  rot1_re,
	input  logic [COMP_WIDTH-1:0]  rot1_im,
	input  logic [COMP_WIDTH-1:0]  rot2_re,
	input  logic [COMP_WIDTH-1:0]  rot2_im,
	input  logic                   saturated_flag
);
	import r2tfr_pkg::*;

	localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

	localparam logic [CNT_W-1:0]      DEPTH_C = CNT_W'(PIPE_DEPTH);
	localparam logic [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
	localparam logic [COMP_WIDTH-1:0] SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

	logic             in_acc, out_acc;
	logic [CNT_W-1:0] inflight_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - CNT_W'(1);
		end
	end

	`R2TFR_ASSERT_ALWAYS(a_idle_in_reset, clk, !arst_n |-> !out_valid, "result valid during reset")

	`R2TFR_ASSERT(a_hold_stalled, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(rot0_re) && $stable(rot1_re) && $stable(rot1_im) && $stable(rot2_re) && $stable(rot2_im) && $stable(saturated_flag), "stalled result changed")

	`R2TFR_ASSERT(a_flag_means_clip, clk, arst_n, out_valid && saturated_flag |-> rot0_re == SAT_MAX || rot0_re == SAT_MIN || rot1_re == SAT_MAX || rot1_re == SAT_MIN || rot1_im == SAT_MAX || rot1_im == SAT_MIN || rot2_re == SAT_MAX || rot2_re == SAT_MIN || rot2_im == SAT_MAX || rot2_im == SAT_MIN, "flag set with no clipped part")

	`R2TFR_ASSERT(a_inflight_bound, clk, arst_n, inflight_q <= DEPTH_C, "more items in flight than stages")

	`R2TFR_ASSERT(a_no_invented, clk, arst_n, out_valid |-> inflight_q != '0, "result with no item in flight")

endmodule

bind rank2_tensor_frame_rotation_top r2tfr_checker #(
	.COMP_WIDTH(COMP_WIDTH)
) u_r2tfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (item_in.valid),
	.in_ready       (item_in.ready),
	.out_valid      (item_out.valid),
	.out_ready      (item_out.ready),
	.rot0_re        (item_out.rot0_re),
	.rot1_re        (item_out.rot1_re),
	.rot1_im        (item_out.rot1_im),
	.rot2_re        (item_out.rot2_re),
	.rot2_im        (item_out.rot2_im),
	.saturated_flag (item_out.saturated_flag)
);
